// ===== hdl/segment_box_clipper_assert.svh =====
// Assertion macros for the segment box clipper.
// Needs i_clk and i_rst_n in the scope that uses them.
`ifndef SEGMENT_BOX_CLIPPER_ASSERT_SVH
`define SEGMENT_BOX_CLIPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment_box_clipper: implication check failed");

// Condition must hold at every edge out of reset.
`define SBC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("segment_box_clipper: invariant check failed");

`endif

// ===== hdl/sbc_pkg.sv =====
// Shared types, constants and step table for the segment box clipper.
// No dependencies.
`default_nettype none

package sbc_pkg;

    localparam int CB        = 32;
    localparam int NSTEP     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_LAT   = CB + 1;
    localparam int STEP_LAT  = DIV_LAT + 3;
    localparam int LAT       = NSTEP * STEP_LAT;

    typedef logic signed [CB-1:0] t_coord;
    typedef logic [CB-1:0]        t_mag;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        logic   modified;
    } t_seg;

    typedef struct packed {
        logic axis_y;
        logic on_end;
        logic above;
    } t_step_ctl;

    typedef struct packed {
        t_seg   seg;
        t_coord bound;
        logic   fire;
        logic   interp;
        logic   neg;
    } t_side;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEST  = 2'd0,
        REG_EAST  = 2'd1,
        REG_SOUTH = 2'd2,
        REG_NORTH = 2'd3
    } t_reg_idx;

    // Step order: x steps then y steps; start before end; below before above.
    function automatic t_step_ctl step_ctl(input logic [2:0] k);
        t_step_ctl c;
        c.axis_y = k[2];
        c.on_end = k[1];
        c.above  = k[0];
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on sbc_pkg.
`default_nettype none

module sbc_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [2*sbc_pkg::CB-1:0] i_num,
    input  wire sbc_pkg::t_mag    i_den,
    input  wire sbc_pkg::t_side   i_side,
    output logic                  o_valid,
    output sbc_pkg::t_mag         o_quo,
    output logic                  o_ovf,
    output sbc_pkg::t_side        o_side
);

    localparam int CB = sbc_pkg::CB;

    logic            r_valid [0:CB];
    sbc_pkg::t_mag   r_rem   [0:CB];
    sbc_pkg::t_mag   r_low   [0:CB];
    sbc_pkg::t_mag   r_quo   [0:CB];
    sbc_pkg::t_mag   r_den   [0:CB];
    logic            r_ovf   [0:CB];
    sbc_pkg::t_side  r_side  [0:CB];

    // Quotient fits CB bits only if the high half is below the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
        r_rem[0]  <= i_num[2*CB-1:CB];
        r_low[0]  <= i_num[CB-1:0];
        r_quo[0]  <= '0;
        r_den[0]  <= i_den;
        r_ovf[0]  <= (i_num[2*CB-1:CB] >= i_den);
        r_side[0] <= i_side;
    end

    for (genvar k = 1; k <= CB; k++) begin : g_stage
        logic [CB:0] trial;
        logic [CB:0] diff;
        logic        take;

        always_comb begin
            trial = {r_rem[k-1], r_low[k-1][CB-1]};
            diff  = trial - {1'b0, r_den[k-1]};
            take  = (trial >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= r_valid[k-1];
            end
            r_rem[k]  <= take ? diff[CB-1:0] : trial[CB-1:0];
            r_low[k]  <= {r_low[k-1][CB-2:0], 1'b0};
            r_quo[k]  <= {r_quo[k-1][CB-2:0], take};
            r_den[k]  <= r_den[k-1];
            r_ovf[k]  <= r_ovf[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_valid[CB];
    assign o_quo   = r_quo[CB];
    assign o_ovf   = r_ovf[CB];
    assign o_side  = r_side[CB];

endmodule

`default_nettype wire

// ===== hdl/sbc_step.sv =====
// One clipping step: compare, scale, divide and clamp one coordinate.
// Depends on sbc_pkg and sbc_div.
`default_nettype none

module sbc_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire sbc_pkg::t_seg      i_seg,
    input  wire sbc_pkg::t_step_ctl i_ctl,
    input  wire sbc_pkg::t_coord    i_bound,
    output logic                    o_valid,
    output sbc_pkg::t_seg           o_seg
);

    localparam int CB = sbc_pkg::CB;

    // Stage A: select roles, compare and take magnitudes
    logic signed [CB-1:0] p, q, pf, qf;
    logic signed [CB:0]   a, c, d;
    logic [CB:0]          aa, ac, ad;
    logic                 fire;
    sbc_pkg::t_side       side_a;

    always_comb begin
        case ({i_ctl.axis_y, i_ctl.on_end})
            2'b00:   begin p = i_seg.sx; q = i_seg.sy; pf = i_seg.ex; qf = i_seg.ey; end
            2'b01:   begin p = i_seg.ex; q = i_seg.ey; pf = i_seg.sx; qf = i_seg.sy; end
            2'b10:   begin p = i_seg.sy; q = i_seg.sx; pf = i_seg.ey; qf = i_seg.ex; end
            default: begin p = i_seg.ey; q = i_seg.ex; pf = i_seg.sy; qf = i_seg.sx; end
        endcase
        a  = {i_bound[CB-1], i_bound} - {p[CB-1], p};
        c  = {qf[CB-1], qf} - {q[CB-1], q};
        d  = {pf[CB-1], pf} - {p[CB-1], p};
        aa = a[CB] ? -a : a;
        ac = c[CB] ? -c : c;
        ad = d[CB] ? -d : d;
        fire = i_ctl.above ? ($signed(p) > $signed(i_bound))
                           : ($signed(p) < $signed(i_bound));
        side_a.seg    = i_seg;
        side_a.bound  = i_bound;
        side_a.fire   = fire;
        side_a.interp = fire && (pf != p);
        side_a.neg    = a[CB] ^ c[CB] ^ d[CB];
    end

    logic            r_a_valid;
    sbc_pkg::t_side  r_a_side;
    sbc_pkg::t_mag   r_a_ma, r_a_mc, r_a_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_side <= side_a;
        r_a_ma   <= aa[CB-1:0];
        r_a_mc   <= ac[CB-1:0];
        r_a_md   <= ad[CB-1:0];
    end

    // Stage M: exact product of magnitudes
    logic                 r_m_valid;
    sbc_pkg::t_side       r_m_side;
    logic [2*CB-1:0]      r_m_prod;
    sbc_pkg::t_mag        r_m_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= r_a_valid;
        end
        r_m_side <= r_a_side;
        r_m_prod <= r_a_ma * r_a_mc;
        r_m_md   <= r_a_md;
    end

    logic            w_d_valid;
    sbc_pkg::t_mag   w_d_quo;
    logic            w_d_ovf;
    sbc_pkg::t_side  w_d_side;

    sbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_valid),
        .i_num   (r_m_prod),
        .i_den   (r_m_md),
        .i_side  (r_m_side),
        .o_valid (w_d_valid),
        .o_quo   (w_d_quo),
        .o_ovf   (w_d_ovf),
        .o_side  (w_d_side)
    );

    // Final stage: add, saturate and write back
    sbc_pkg::t_seg        s;
    logic signed [CB-1:0] fq, sat, newq, newp;
    logic signed [CB+1:0] sum;
    logic                 hi_ovf;

    always_comb begin
        s = w_d_side.seg;
        case ({i_ctl.axis_y, i_ctl.on_end})
            2'b00:   fq = s.sy;
            2'b01:   fq = s.ey;
            2'b10:   fq = s.sx;
            default: fq = s.ex;
        endcase
        sum = w_d_side.neg ? ({{2{fq[CB-1]}}, fq} - {2'b00, w_d_quo})
                           : ({{2{fq[CB-1]}}, fq} + {2'b00, w_d_quo});
        hi_ovf = !((sum[CB+1:CB-1] == 3'b000) || (sum[CB+1:CB-1] == 3'b111));
        if (w_d_ovf) begin
            sat = w_d_side.neg ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end else if (hi_ovf) begin
            sat = sum[CB+1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end else begin
            sat = sum[CB-1:0];
        end
        newq = w_d_side.interp ? sat : fq;
        case ({i_ctl.axis_y, i_ctl.on_end})
            2'b00:   begin newp = w_d_side.fire ? w_d_side.bound : s.sx; s.sx = newp; s.sy = newq; end
            2'b01:   begin newp = w_d_side.fire ? w_d_side.bound : s.ex; s.ex = newp; s.ey = newq; end
            2'b10:   begin newp = w_d_side.fire ? w_d_side.bound : s.sy; s.sy = newp; s.sx = newq; end
            default: begin newp = w_d_side.fire ? w_d_side.bound : s.ey; s.ey = newp; s.ex = newq; end
        endcase
        s.modified = s.modified | w_d_side.fire;
    end

    logic           r_o_valid;
    sbc_pkg::t_seg  r_o_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= w_d_valid;
        end
        r_o_seg <= s;
    end

    assign o_valid = r_o_valid;
    assign o_seg   = r_o_seg;

endmodule

`default_nettype wire

// ===== hdl/segment_box_clipper.sv =====
// Segment box clipper: eight clipping steps chained into one pipeline.
// Depends on sbc_pkg, sbc_step and segment_box_clipper_assert.svh.
`default_nettype none

// Accepts one segment per clock whenever i_start is high; o_busy is always low.
// Each result appears on o_done once its item has passed through the pipeline
// (eight steps of 36 stages each: operand setup, a 32x32 multiply, then a
// 33-stage bit-per-stage divider and a saturating write-back). Results come out
// in order and cannot be held off. Write the bounds only while no item is in
// flight.

`include "segment_box_clipper_assert.svh"

module segment_box_clipper (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    output logic                                    o_busy,
    input  wire logic signed [sbc_pkg::CB-1:0]      i_start_x,
    input  wire logic signed [sbc_pkg::CB-1:0]      i_start_y,
    input  wire logic signed [sbc_pkg::CB-1:0]      i_end_x,
    input  wire logic signed [sbc_pkg::CB-1:0]      i_end_y,
    input  wire logic                               i_cfg_we,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [sbc_pkg::CB-1:0]             i_cfg_data,
    output logic                                    o_done,
    output logic signed [sbc_pkg::CB-1:0]           o_clipped_start_x,
    output logic signed [sbc_pkg::CB-1:0]           o_clipped_start_y,
    output logic signed [sbc_pkg::CB-1:0]           o_clipped_end_x,
    output logic signed [sbc_pkg::CB-1:0]           o_clipped_end_y,
    output logic                                    o_was_modified
);

    localparam int CB    = sbc_pkg::CB;
    localparam int NSTEP = sbc_pkg::NSTEP;

    sbc_pkg::t_coord r_west, r_east, r_south, r_north;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_west  <= {1'b1, {(CB-1){1'b0}}};
            r_east  <= {1'b0, {(CB-1){1'b1}}};
            r_south <= {1'b1, {(CB-1){1'b0}}};
            r_north <= {1'b0, {(CB-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (sbc_pkg::t_reg_idx'(i_cfg_idx))
                sbc_pkg::REG_WEST:  r_west  <= i_cfg_data;
                sbc_pkg::REG_EAST:  r_east  <= i_cfg_data;
                sbc_pkg::REG_SOUTH: r_south <= i_cfg_data;
                sbc_pkg::REG_NORTH: r_north <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic           w_valid [0:NSTEP];
    sbc_pkg::t_seg  w_seg   [0:NSTEP];

    always_comb begin
        w_valid[0]        = i_start;
        w_seg[0].sx       = i_start_x;
        w_seg[0].sy       = i_start_y;
        w_seg[0].ex       = i_end_x;
        w_seg[0].ey       = i_end_y;
        w_seg[0].modified = 1'b0;
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        sbc_pkg::t_step_ctl ctl;
        sbc_pkg::t_coord    bound;

        always_comb begin
            ctl = sbc_pkg::step_ctl(3'(k));
            if (ctl.axis_y) begin
                bound = ctl.above ? r_north : r_south;
            end else begin
                bound = ctl.above ? r_east : r_west;
            end
        end

        sbc_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_seg   (w_seg[k]),
            .i_ctl   (ctl),
            .i_bound (bound),
            .o_valid (w_valid[k+1]),
            .o_seg   (w_seg[k+1])
        );
    end

    assign o_busy            = 1'b0;
    assign o_done            = w_valid[NSTEP];
    assign o_clipped_start_x = w_seg[NSTEP].sx;
    assign o_clipped_start_y = w_seg[NSTEP].sy;
    assign o_clipped_end_x   = w_seg[NSTEP].ex;
    assign o_clipped_end_y   = w_seg[NSTEP].ey;
    assign o_was_modified    = w_seg[NSTEP].modified;

    `SBC_ASSERT_ALWAYS(a_done_has_source, !o_done || $past(i_start, sbc_pkg::LAT))
    `SBC_ASSERT_IMP(a_unmodified_passes, o_done && !o_was_modified, (o_clipped_start_x == $past(i_start_x, sbc_pkg::LAT)) && (o_clipped_start_y == $past(i_start_y, sbc_pkg::LAT)) && (o_clipped_end_x == $past(i_end_x, sbc_pkg::LAT)) && (o_clipped_end_y == $past(i_end_y, sbc_pkg::LAT)))

endmodule

`default_nettype wire
